@@ src/fp32_divider_unit_assert.svh @@
// assertion macros for the divider
`ifndef FP32_DIVIDER_UNIT_ASSERT_SVH
`define FP32_DIVIDER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FDIV_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define FDIV_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define FDIV_ASSERT_IMP(label, clk, rst, a, c)
`define FDIV_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ src/fdiv_pkg.sv @@
// ----------------------------------------------------------------------------
// fdiv_pkg
// types and constants used by fp32_divider_unit
// ----------------------------------------------------------------------------
package fdiv_pkg;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FC00000;
  localparam logic [7:0] EXP_ONES = 8'hFF;
  localparam int SIG_W = 24;
  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_DIV, ST_SHIFT, ST_ROUND, ST_OUT
  } state_t;
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } ctrl_t;
endpackage

@@ src/fdiv_step.sv @@
// ----------------------------------------------------------------------------
// fdiv_step
// one restoring division step: compare, subtract, shift
// ----------------------------------------------------------------------------
module fdiv_step (
  input  logic [25:0] num,
  input  logic [23:0] den,
  output logic [25:0] num_next,
  output logic        qbit
);
  logic [25:0] diff;
  assign diff = num - {2'b00, den};
  assign qbit = (num >= {2'b00, den});
  assign num_next = qbit ? {diff[24:0], 1'b0} : {num[24:0], 1'b0};
endmodule

@@ src/fp32_divider_unit.sv @@
// ----------------------------------------------------------------------------
// fp32_divider_unit
// binary32 division, round to nearest even, one shared step unit
// ----------------------------------------------------------------------------
// channel  signals                                   dir
// in       in_valid in_stall dividend_bits divisor_bits  in
// out      out_valid out_stall quotient_bits            out
// special operands go from idle straight to output; others pass normalize (up to
// 46 subnormal shifts), divide, denormalize shift (up to 151 shifts), round
// and output; the divide state forms 24+GUARD_BITS quotient bits (27 by
// default) in a loop through the shared step unit
// in_stall is high whenever an item is in work or its result waits
// rst clears the sequencer only
module fp32_divider_unit #(
  parameter int GUARD_BITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] dividend_bits,
  input  logic [31:0] divisor_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] quotient_bits
);
`include "fp32_divider_unit_assert.svh"
  localparam int QW = fdiv_pkg::SIG_W + GUARD_BITS;
  localparam int CW = $clog2(QW + 1);

  fdiv_pkg::state_t state, state_next;
  fdiv_pkg::ctrl_t ctrl;
  logic [25:0] num;
  logic [23:0] den;
  logic [QW-1:0] q;
  logic [CW-1:0] cnt;
  logic signed [10:0] xr;
  logic sr, special;
  logic [31:0] res;
  logic [25:0] step_num;
  logic step_q;

  fdiv_step u_step (.num(num), .den(den), .num_next(step_num), .qbit(step_q));

  assign ctrl.start = in_valid && !in_stall;
  assign ctrl.busy = (state != fdiv_pkg::ST_IDLE);
  assign ctrl.done = out_valid && !out_stall;
  assign in_stall = ctrl.busy;
  assign out_valid = (state == fdiv_pkg::ST_OUT);
  assign quotient_bits = res;

  logic [7:0] ea, eb;
  logic [22:0] fa, fb;
  logic an, bn, ai, bi, az, bz;
  assign ea = dividend_bits[30:23];
  assign eb = divisor_bits[30:23];
  assign fa = dividend_bits[22:0];
  assign fb = divisor_bits[22:0];
  assign an = (ea == fdiv_pkg::EXP_ONES) && (fa != '0);
  assign bn = (eb == fdiv_pkg::EXP_ONES) && (fb != '0);
  assign ai = (ea == fdiv_pkg::EXP_ONES) && (fa == '0);
  assign bi = (eb == fdiv_pkg::EXP_ONES) && (fb == '0);
  assign az = (dividend_bits[30:0] == '0);
  assign bz = (divisor_bits[30:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdiv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic normed, fin_sh;
  logic [QW-1:0] q_sh;
  logic [GUARD_BITS-1:0] low;
  logic [QW-GUARD_BITS:0] mant;
  logic rnd;
  logic [31:0] bits;
  assign normed = num[23] && den[23];
  assign fin_sh = (xr >= 11'sd1);
  assign low = q[GUARD_BITS-1:0];
  assign rnd = (low > {1'b1, {(GUARD_BITS-1){1'b0}}}) ||
               ((low == {1'b1, {(GUARD_BITS-1){1'b0}}}) && q[GUARD_BITS]);
  assign mant = {1'b0, q[QW-1:GUARD_BITS]} + {{(QW-GUARD_BITS){1'b0}}, rnd};
  assign q_sh = {1'b0, q[QW-1:1]} | {{(QW-1){1'b0}}, q[0]};

  always_comb begin
    bits = ({21'd0, xr - 11'sd1} << 23) + {{(32-QW+GUARD_BITS-1){1'b0}}, mant};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fdiv_pkg::ST_IDLE: if (ctrl.start) state_next = special ?
                                             fdiv_pkg::ST_OUT : fdiv_pkg::ST_NORM;
      fdiv_pkg::ST_NORM: if (normed) state_next = fdiv_pkg::ST_DIV;
      fdiv_pkg::ST_DIV: if (cnt == CW'(QW - 1)) state_next = fdiv_pkg::ST_SHIFT;
      fdiv_pkg::ST_SHIFT: if (fin_sh) state_next = fdiv_pkg::ST_ROUND;
      fdiv_pkg::ST_ROUND: state_next = fdiv_pkg::ST_OUT;
      fdiv_pkg::ST_OUT: if (ctrl.done) state_next = fdiv_pkg::ST_IDLE;
      default: state_next = fdiv_pkg::ST_IDLE;
    endcase
  end

  logic [31:0] res_sp;
  logic sgn;
  assign sgn = dividend_bits[31] ^ divisor_bits[31];

  always_comb begin
    special = 1'b1;
    if (an) res_sp = dividend_bits;
    else if (bn) res_sp = divisor_bits;
    else if (ai) res_sp = bi ? fdiv_pkg::DEFAULT_NAN : {sgn, fdiv_pkg::EXP_ONES, 23'd0};
    else if (bi) res_sp = {sgn, 31'd0};
    else if (bz) res_sp = az ? fdiv_pkg::DEFAULT_NAN : {sgn, fdiv_pkg::EXP_ONES, 23'd0};
    else if (az) res_sp = {sgn, 31'd0};
    else begin
      special = 1'b0;
      res_sp = '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      fdiv_pkg::ST_IDLE: begin
        res <= res_sp;
        sr <= sgn;
        num <= {2'b00, (ea != 0), fa};
        den <= {(eb != 0), fb};
        xr <= $signed({3'b000, (ea != 0) ? ea : 8'd1}) -
              $signed({3'b000, (eb != 0) ? eb : 8'd1}) + 11'sd127;
        cnt <= '0;
        q <= '0;
      end
      fdiv_pkg::ST_NORM: begin
        if (!num[23]) begin
          num <= {num[24:0], 1'b0};
          xr <= xr - 11'sd1;
        end else if (!den[23]) begin
          den <= {den[22:0], 1'b0};
          xr <= xr + 11'sd1;
        end else if (num[23:0] < den) begin
          num <= {num[24:0], 1'b0};
          xr <= xr - 11'sd1;
        end
      end
      fdiv_pkg::ST_DIV: begin
        num <= step_num;
        q <= {q[QW-2:0], step_q};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) q <= {q[QW-2:0], step_q | (step_num != '0)};
      end
      fdiv_pkg::ST_SHIFT: begin
        if (!fin_sh) begin
          q <= q_sh;
          xr <= xr + 11'sd1;
        end
      end
      fdiv_pkg::ST_ROUND: begin
        if (xr >= 11'sd255 || bits >= 32'h7F800000)
          res <= {sr, fdiv_pkg::EXP_ONES, 23'd0};
        else
          res <= {sr, bits[30:0]};
      end
      fdiv_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  `FDIV_ASSERT_IMP(a_no_take_busy, clk, rst, ctrl.busy, in_stall)
  `FDIV_ASSERT_NEXT(a_done_idle, clk, rst, ctrl.done, state == fdiv_pkg::ST_IDLE)
  `FDIV_ASSERT_IMP(a_div_norm, clk, rst, state == fdiv_pkg::ST_DIV, den[23])
endmodule
